### hdl/datagram_fragment_reassembly_defines.svh
// Assertion macros for the reassembly block.
`ifndef DATAGRAM_FRAGMENT_REASSEMBLY_DEFINES_SVH
`define DATAGRAM_FRAGMENT_REASSEMBLY_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define DFR_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("%m: check failed");
`define DFR_ASSERT_ALWAYS(name, clk, prop) \
  name: assert property (@(posedge clk) prop) else $error("%m: check failed");
`else
`define DFR_ASSERT(name, clk, rst_n, prop)
`define DFR_ASSERT_ALWAYS(name, clk, prop)
`endif
`endif

### hdl/dfr_pkg.sv
package dfr_pkg;

  localparam int unsigned MAX_FRAGMENTS = 8192;
  localparam int unsigned MAX_PAYLOAD   = 1200;
  localparam int unsigned HEADER_BYTES  = 16;
  localparam int unsigned SLOT_W        = 13;
  localparam int unsigned COUNT_W       = 14;
  localparam int unsigned LEN_W         = 11;
  localparam int unsigned BYTES_W       = 24;
  localparam int unsigned AGE_W         = 16;
  localparam int unsigned ADDR48_W      = 48;
  localparam int unsigned EPOCH_W       = 8;

  localparam int unsigned IN_DATA_W  = 184;
  localparam int unsigned OUT_DATA_W = 128;
  localparam int unsigned CFG_DATA_W = 48;
  localparam int unsigned CFG_IDX_W  = 3;

  localparam logic [31:0]         MAGIC_RST       = 32'h4F53_5544;
  localparam logic [7:0]          VERSION_RST     = 8'd2;
  localparam logic [7:0]          VIDEO_RST       = 8'd0;
  localparam logic [15:0]         TIMEOUT_RST     = 16'd250;
  localparam logic [23:0]         MAX_BYTES_RST   = 24'd8388608;
  localparam logic                PRESET_EN_RST   = 1'b0;
  localparam logic [ADDR48_W-1:0] PRESET_ADDR_RST = '0;

  typedef enum logic [1:0] {
    OP_DATAGRAM = 2'd0,
    OP_TICK     = 2'd1,
    OP_CLEAR    = 2'd2
  } op_e;

  typedef enum logic [3:0] {
    DISP_NONE      = 4'd0,
    DISP_STALE     = 4'd1,
    DISP_SHORT     = 4'd2,
    DISP_BAD_HDR   = 4'd3,
    DISP_FOREIGN   = 4'd4,
    DISP_ACK_SEEN  = 4'd5,
    DISP_BAD_FRAG  = 4'd6,
    DISP_OLDER     = 4'd7,
    DISP_STORED    = 4'd8,
    DISP_DUPLICATE = 4'd9
  } disp_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAGIC       = 3'd0,
    CFG_VERSION     = 3'd1,
    CFG_VIDEO_TYPE  = 3'd2,
    CFG_TIMEOUT     = 3'd3,
    CFG_MAX_BYTES   = 3'd4,
    CFG_PRESET_EN   = 3'd5,
    CFG_PRESET_ADDR = 3'd6
  } cfg_idx_e;

  typedef struct packed {
    logic [31:0]         magic_value;
    logic [7:0]          protocol_version;
    logic [7:0]          video_type_code;
    logic [15:0]         stale_timeout_ms;
    logic [23:0]         max_message_bytes;
    logic                preset_peer_enable;
    logic [ADDR48_W-1:0] preset_peer_address;
  } cfg_t;

  typedef struct packed {
    logic [4:0]          pad;
    logic [15:0]         fragment_count;
    logic [15:0]         fragment_index;
    logic [31:0]         message_id;
    logic [7:0]          message_type;
    logic [7:0]          packet_flags;
    logic [ADDR48_W-1:0] source_address;
    logic [7:0]          header_version;
    logic [31:0]         header_magic;
    logic [LEN_W-1:0]    datagram_bytes;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         pad;
    logic [31:0]        last_acked_id;
    logic               oversize_dropped;
    logic [BYTES_W-1:0] done_bytes;
    logic [7:0]         done_type;
    logic               message_done;
    logic [LEN_W-1:0]   fragment_length;
    logic [SLOT_W-1:0]  fragment_slot;
    logic               store_fragment;
    logic               assembly_restarted;
    logic [31:0]        ack_for_id;
    logic               send_ack;
  } out_word_t;

  typedef struct packed {
    logic              rd_en;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [SLOT_W-1:0] wr_addr;
    logic              bump;
  } seen_req_t;

endpackage

### hdl/dfr_cfg.sv
module dfr_cfg
  import dfr_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output cfg_t                  cfg_o
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.magic_value         <= MAGIC_RST;
      cfg_q.protocol_version    <= VERSION_RST;
      cfg_q.video_type_code     <= VIDEO_RST;
      cfg_q.stale_timeout_ms    <= TIMEOUT_RST;
      cfg_q.max_message_bytes   <= MAX_BYTES_RST;
      cfg_q.preset_peer_enable  <= PRESET_EN_RST;
      cfg_q.preset_peer_address <= PRESET_ADDR_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_MAGIC:       cfg_q.magic_value         <= cfg_data_i[31:0];
        CFG_VERSION:     cfg_q.protocol_version    <= cfg_data_i[7:0];
        CFG_VIDEO_TYPE:  cfg_q.video_type_code     <= cfg_data_i[7:0];
        CFG_TIMEOUT:     cfg_q.stale_timeout_ms    <= cfg_data_i[15:0];
        CFG_MAX_BYTES:   cfg_q.max_message_bytes   <= cfg_data_i[23:0];
        CFG_PRESET_EN:   cfg_q.preset_peer_enable  <= cfg_data_i[0];
        CFG_PRESET_ADDR: cfg_q.preset_peer_address <= cfg_data_i[ADDR48_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg_o = cfg_q;

endmodule

### hdl/dfr_seen.sv
// Fragment seen-bitmap as an epoch-tagged memory. An entry counts as seen when
// its tag matches the current epoch; epoch wrap and reset run a tag sweep.
module dfr_seen
  import dfr_pkg::*;
#(
  parameter int unsigned EpochW = EPOCH_W
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  seen_req_t req_i,
  output logic      seen_o,
  output logic      busy_o
);

  localparam logic [EpochW-1:0] EpochMax   = {EpochW{1'b1}};
  localparam logic [EpochW-1:0] EpochFirst = EpochW'(1);
  localparam logic [SLOT_W-1:0] LastAddr   = SLOT_W'(MAX_FRAGMENTS - 1);

  logic [EpochW-1:0] tag_mem [MAX_FRAGMENTS];

  logic [EpochW-1:0] epoch_q, epoch_inc, wr_tag;
  logic              clearing_q;
  logic [SLOT_W-1:0] clr_addr_q;
  logic              pend_v_q;
  logic [SLOT_W-1:0] pend_addr_q;
  logic              stale_q;
  logic              fwd_v_q;
  logic [SLOT_W-1:0] fwd_addr_q;
  logic [EpochW-1:0] fwd_tag_q;
  logic [EpochW-1:0] rdata_q;
  logic [SLOT_W-1:0] rd_addr_q;
  logic              wrap;
  logic              mem_we;
  logic [SLOT_W-1:0] mem_wa;
  logic [EpochW-1:0] mem_wd;

  assign epoch_inc = epoch_q + EpochW'(1);
  assign wrap      = req_i.bump && (epoch_q == EpochMax);
  assign wr_tag    = req_i.bump ? epoch_inc : epoch_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_q     <= EpochFirst;
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      pend_v_q    <= 1'b0;
      pend_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + SLOT_W'(1);
      if (clr_addr_q == LastAddr) begin
        clearing_q <= 1'b0;
        pend_v_q   <= 1'b0;
      end
    end else if (wrap) begin
      // write of the wrapping step is replayed by the sweep with the first tag
      clearing_q  <= 1'b1;
      clr_addr_q  <= '0;
      epoch_q     <= EpochFirst;
      pend_v_q    <= req_i.wr_en;
      pend_addr_q <= req_i.wr_addr;
    end else if (req_i.bump) begin
      epoch_q <= epoch_inc;
    end
  end

  // the forward entry keeps the last write, with the first tag for a wrapping step, for the word read beside it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stale_q    <= 1'b1;
      fwd_v_q    <= 1'b0;
      fwd_addr_q <= '0;
      fwd_tag_q  <= '0;
    end else begin
      if (clearing_q) begin
        stale_q <= 1'b1;
      end else if (req_i.rd_en) begin
        stale_q <= 1'b0;
      end
      if (req_i.wr_en) begin
        fwd_v_q    <= 1'b1;
        fwd_addr_q <= req_i.wr_addr;
        fwd_tag_q  <= wrap ? EpochFirst : wr_tag;
      end else if (wrap) begin
        fwd_v_q <= 1'b0;
      end
    end
  end

  assign mem_we = clearing_q || (req_i.wr_en && !wrap);
  assign mem_wa = clearing_q ? clr_addr_q : req_i.wr_addr;
  assign mem_wd = clearing_q ?
                  ((pend_v_q && (pend_addr_q == clr_addr_q)) ? EpochFirst : '0) : wr_tag;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      tag_mem[mem_wa] <= mem_wd;
    end
    if (req_i.rd_en) begin
      rdata_q   <= tag_mem[req_i.rd_addr];
      rd_addr_q <= req_i.rd_addr;
    end
  end

  assign seen_o = (!stale_q && (rdata_q == epoch_q)) ||
                  (fwd_v_q && (fwd_addr_q == rd_addr_q) && (fwd_tag_q == epoch_q));
  assign busy_o = clearing_q;

endmodule

### hdl/dfr_core.sv
module dfr_core
  import dfr_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cfg_t       cfg_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  in_word_t   in_data_i,
  input  logic [1:0] in_op_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output out_word_t  out_data_o,
  output logic [3:0] out_disp_o,
  output seen_req_t  seen_req_o,
  input  logic       seen_i,
  input  logic       busy_i
);

  logic                s1_v_q;
  logic [1:0]          s1_op_q;
  in_word_t            s1_q;

  logic                peer_known_q, peer_known_d;
  logic [ADDR48_W-1:0] peer_addr_q, peer_addr_d;
  logic                active_q, active_d;
  logic [31:0]         aid_q, aid_d;
  logic [7:0]          atype_q, atype_d;
  logic [COUNT_W-1:0]  acount_q, acount_d;
  logic [COUNT_W-1:0]  rcvd_q, rcvd_d;
  logic [BYTES_W-1:0]  bt_q, bt_d;
  logic [AGE_W-1:0]    age_q, age_d;
  logic [31:0]         acked_q, acked_d;

  logic                out_v_q;
  out_word_t           out_q;
  logic [3:0]          out_disp_q;

  logic                fire, accept;
  out_word_t           res;
  disp_e               disp;
  logic                drop, wr_en, bump;

  logic [LEN_W-1:0]    plen;
  logic                is_short, bad_hdr, foreign, ack_pkt, bad_frag, reliable;
  logic                conflict, preempt, older, restart, new_asm;
  logic [COUNT_W-1:0]  eff_count, base_rcvd;
  logic [BYTES_W-1:0]  base_bt;
  logic [7:0]          eff_type;
  logic                bad_idx, seen_eff;
  logic [BYTES_W:0]    bt_sum;
  logic [AGE_W-1:0]    age_n;

  assign fire       = s1_v_q && !busy_i && (!out_v_q || out_ready_i);
  assign in_ready_o = !busy_i && (!s1_v_q || fire);
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (accept) begin
      s1_v_q <= 1'b1;
    end else if (fire) begin
      s1_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_q    <= in_data_i;
      s1_op_q <= in_op_i;
    end
  end

  assign plen     = s1_q.datagram_bytes - LEN_W'(HEADER_BYTES);
  assign is_short = s1_q.datagram_bytes < LEN_W'(HEADER_BYTES);
  assign bad_hdr  = (s1_q.header_magic != cfg_i.magic_value) ||
                    (s1_q.header_version != cfg_i.protocol_version);
  assign foreign  = peer_known_q && (s1_q.source_address != peer_addr_q);
  assign ack_pkt  = s1_q.packet_flags[1];
  assign reliable = s1_q.packet_flags[0];
  assign bad_frag = (s1_q.fragment_count == '0) ||
                    (s1_q.fragment_index >= s1_q.fragment_count) ||
                    (plen > LEN_W'(MAX_PAYLOAD)) ||
                    (s1_q.fragment_count > 16'(MAX_FRAGMENTS));

  assign conflict  = active_q && (s1_q.message_id != aid_q);
  assign preempt   = (s1_q.message_type == cfg_i.video_type_code) ||
                     (s1_q.message_id > aid_q) || (rcvd_q == '0);
  assign older     = conflict && !preempt;
  assign restart   = conflict && preempt;
  assign new_asm   = !active_q || restart;
  assign eff_count = new_asm ? s1_q.fragment_count[COUNT_W-1:0] : acount_q;
  assign eff_type  = new_asm ? s1_q.message_type : atype_q;
  assign base_rcvd = new_asm ? '0 : rcvd_q;
  assign base_bt   = new_asm ? '0 : bt_q;
  assign bad_idx   = s1_q.fragment_index >= 16'(eff_count);
  assign seen_eff  = !new_asm && seen_i;
  assign bt_sum    = {1'b0, base_bt} + (BYTES_W + 1)'(plen);
  assign age_n     = (age_q != {AGE_W{1'b1}}) ? age_q + AGE_W'(1) : age_q;

  always_comb begin
    peer_known_d = peer_known_q;
    peer_addr_d  = peer_addr_q;
    active_d     = active_q;
    aid_d        = aid_q;
    atype_d      = atype_q;
    acount_d     = acount_q;
    rcvd_d       = rcvd_q;
    bt_d         = bt_q;
    age_d        = age_q;
    acked_d      = acked_q;
    res          = '0;
    disp         = DISP_NONE;
    drop         = 1'b0;
    wr_en        = 1'b0;
    case (s1_op_q)
      OP_TICK: begin
        if (active_q) begin
          if (age_n > cfg_i.stale_timeout_ms) begin
            drop = 1'b1;
            disp = DISP_STALE;
          end else begin
            age_d = age_n;
          end
        end
      end
      OP_CLEAR: begin
        peer_known_d = cfg_i.preset_peer_enable;
        peer_addr_d  = cfg_i.preset_peer_address;
        drop         = 1'b1;
        acked_d      = '0;
      end
      OP_DATAGRAM: begin
        if (is_short) begin
          disp = DISP_SHORT;
        end else if (bad_hdr) begin
          disp = DISP_BAD_HDR;
        end else if (foreign) begin
          disp = DISP_FOREIGN;
        end else begin
          if (!peer_known_q) begin
            peer_known_d = 1'b1;
            peer_addr_d  = s1_q.source_address;
          end
          if (ack_pkt) begin
            acked_d = s1_q.message_id;
            disp    = DISP_ACK_SEEN;
          end else if (bad_frag) begin
            disp = DISP_BAD_FRAG;
          end else begin
            res.send_ack   = reliable;
            res.ack_for_id = reliable ? s1_q.message_id : '0;
            if (older) begin
              disp = DISP_OLDER;
            end else begin
              res.assembly_restarted = restart;
              if (new_asm) begin
                active_d = 1'b1;
                aid_d    = s1_q.message_id;
                atype_d  = s1_q.message_type;
                acount_d = eff_count;
                rcvd_d   = '0;
                bt_d     = '0;
                age_d    = '0;
              end
              if (bad_idx) begin
                disp = DISP_BAD_FRAG;
              end else begin
                if (!seen_eff) begin
                  disp                = DISP_STORED;
                  res.store_fragment  = 1'b1;
                  res.fragment_slot   = s1_q.fragment_index[SLOT_W-1:0];
                  res.fragment_length = plen;
                  rcvd_d              = base_rcvd + COUNT_W'(1);
                  bt_d                = bt_sum[BYTES_W] ? {BYTES_W{1'b1}} :
                                                          bt_sum[BYTES_W-1:0];
                end else begin
                  disp = DISP_DUPLICATE;
                end
                if (rcvd_d == eff_count) begin
                  res.done_type  = eff_type;
                  res.done_bytes = bt_d;
                  if (bt_d <= cfg_i.max_message_bytes) begin
                    res.message_done = 1'b1;
                  end else begin
                    res.oversize_dropped = 1'b1;
                  end
                  drop = 1'b1;
                end else begin
                  wr_en = !seen_eff;
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    if (drop) begin
      active_d = 1'b0;
      aid_d    = '0;
      atype_d  = '0;
      acount_d = '0;
      rcvd_d   = '0;
      bt_d     = '0;
      age_d    = '0;
    end
    res.last_acked_id = acked_d;
  end

  // an old assembly's tags go stale when it is dropped or replaced
  assign bump = active_q && (drop || (s1_op_q == OP_DATAGRAM && restart && disp != DISP_NONE
                                      && res.assembly_restarted));

  assign seen_req_o.rd_en   = accept;
  assign seen_req_o.rd_addr = in_data_i.fragment_index[SLOT_W-1:0];
  assign seen_req_o.wr_en   = fire && wr_en;
  assign seen_req_o.wr_addr = s1_q.fragment_index[SLOT_W-1:0];
  assign seen_req_o.bump    = fire && bump;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      peer_known_q <= PRESET_EN_RST;
      peer_addr_q  <= PRESET_ADDR_RST;
      active_q     <= 1'b0;
      aid_q        <= '0;
      atype_q      <= '0;
      acount_q     <= '0;
      rcvd_q       <= '0;
      bt_q         <= '0;
      age_q        <= '0;
      acked_q      <= '0;
    end else if (fire) begin
      peer_known_q <= peer_known_d;
      peer_addr_q  <= peer_addr_d;
      active_q     <= active_d;
      aid_q        <= aid_d;
      atype_q      <= atype_d;
      acount_q     <= acount_d;
      rcvd_q       <= rcvd_d;
      bt_q         <= bt_d;
      age_q        <= age_d;
      acked_q      <= acked_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (fire) begin
      out_v_q <= 1'b1;
    end else if (out_ready_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q      <= res;
      out_disp_q <= disp;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;
  assign out_disp_o  = out_disp_q;

endmodule

### hdl/datagram_fragment_reassembly.sv
// Pipeline: the input word is registered, then its result word is registered for output.
// Throughput: one word per cycle unless the output stalls or a sweep runs; a seen-tag
// read at acceptance and the read-modify-write of the tag memory as the word fires, with
// write forwarding. Reset: control state clears at once, then a sweep of all 8192 tags
// holds s_axis_tready low; it recurs after 2**EpochW - 1 dropped or replaced assemblies.
`include "datagram_fragment_reassembly_defines.svh"
module datagram_fragment_reassembly
  import dfr_pkg::*;
#(
  parameter int unsigned EpochW = EPOCH_W
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // datagram_bytes, header_magic, header_version, source_address,
  // packet_flags, message_type, message_id, fragment_index, fragment_count
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // operation
  input  logic [1:0]            s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // send_ack, ack_for_id, assembly_restarted, store_fragment, fragment_slot,
  // fragment_length, message_done, done_type, done_bytes, oversize_dropped,
  // last_acked_id
  output logic [OUT_DATA_W-1:0] m_axis_tdata,
  // disposition
  output logic [3:0]            m_axis_tuser
);

  cfg_t      cfg;
  seen_req_t seen_req;
  logic      seen;
  logic      seen_busy;
  out_word_t out_word;

  dfr_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dfr_seen #(
    .EpochW (EpochW)
  ) u_seen (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (seen_req),
    .seen_o (seen),
    .busy_o (seen_busy)
  );

  dfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_data_i   (in_word_t'(s_axis_tdata)),
    .in_op_i     (s_axis_tuser),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (out_word),
    .out_disp_o  (m_axis_tuser),
    .seen_req_o  (seen_req),
    .seen_i      (seen),
    .busy_i      (seen_busy)
  );

  assign m_axis_tdata = OUT_DATA_W'(out_word);

  `DFR_ASSERT(a_sweep_blocks_input, clk_i, rst_ni, seen_busy |-> !s_axis_tready)
  `DFR_ASSERT(a_no_write_in_sweep, clk_i, rst_ni, seen_req.wr_en |-> !seen_busy)
  `DFR_ASSERT(a_store_disp, clk_i, rst_ni, (m_axis_tvalid && out_word.store_fragment) |-> (m_axis_tuser == DISP_STORED))
  `DFR_ASSERT(a_done_excl, clk_i, rst_ni, m_axis_tvalid |-> !(out_word.message_done && out_word.oversize_dropped))
  `DFR_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !m_axis_tvalid)

endmodule

### test/datagram_fragment_reassembly_tb.sv
module datagram_fragment_reassembly_tb;
  import dfr_pkg::*;

  localparam logic [1:0]  OP_UNUSED = 2'd3;
  localparam logic [47:0] PEER_A    = 48'h0A00_0001_1F90;
  localparam logic [47:0] PEER_B    = 48'hC0A8_0102_D431;

  typedef struct packed {
    disp_e     disp;
    out_word_t word;
  } outcome_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [10:0] dlen;
    logic [31:0] magic;
    logic [7:0]  ver;
    logic [47:0] src;
    logic [7:0]  flags;
    logic [7:0]  mtype;
    logic [31:0] mid;
    logic [15:0] fidx;
    logic [15:0] fcnt;
    bit          typed;
    disp_e       disp;
  } row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic [1:0]            s_axis_tuser;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;
  logic [3:0]            m_axis_tuser;

  datagram_fragment_reassembly uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copies
  logic [31:0] want_magic;
  logic [7:0]  want_version;
  logic [7:0]  video_code;
  logic [15:0] tmo_ticks;
  logic [23:0] max_bytes;
  logic        preset_en;
  logic [47:0] preset_addr;

  // session state
  logic              peer_known;
  logic [47:0]       peer_addr;
  logic              asm_active;
  logic [31:0]       asm_id;
  logic [7:0]        asm_type;
  logic [13:0]       asm_count;
  logic [13:0]       rcvd_count;
  logic [23:0]       byte_total;
  logic [15:0]       asm_age;
  bit [MAX_FRAGMENTS-1:0] seen_map;
  logic [31:0]       acked_id;

  outcome_t  pending_results[$];
  int        mismatches = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;
  int        rx_hold_left = 0;

  // message being streamed by the random generator
  logic [31:0] cur_id = 32'd100;
  logic [7:0]  cur_type = 8'd1;
  logic [15:0] cur_cnt = 16'd0;
  logic [15:0] next_frag = 16'd0;

  row_t script [25] = '{
    '{OP_UNUSED,   11'd0,    32'h0,        8'd0,   48'h0,  8'h00, 8'd0,   32'd0,   16'd0,
      16'd0,     1'b1, DISP_NONE},
    '{OP_TICK,     11'd0,    32'h0,        8'd0,   48'h0,  8'h00, 8'd0,   32'd0,   16'd0,
      16'd0,     1'b1, DISP_NONE},
    '{OP_DATAGRAM, 11'd0,    MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd1,     1'b1, DISP_SHORT},
    '{OP_DATAGRAM, 11'd15,   MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd1,     1'b1, DISP_SHORT},
    '{OP_DATAGRAM, 11'd16,   32'hFFFFFFFF, 8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd1,     1'b1, DISP_BAD_HDR},
    '{OP_DATAGRAM, 11'd16,   MAGIC_RST,    8'hFF,  PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd1,     1'b1, DISP_BAD_HDR},
    '{OP_DATAGRAM, 11'd16,   MAGIC_RST,    8'd2,   PEER_A, 8'h02, 8'd0,   32'hFFFFFFFF,
      16'd0,     16'd0, 1'b1, DISP_ACK_SEEN},
    '{OP_DATAGRAM, 11'd1216, MAGIC_RST,    8'd2,   PEER_B, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd1,     1'b1, DISP_FOREIGN},
    '{OP_DATAGRAM, 11'd100,  MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd0,     1'b1, DISP_BAD_FRAG},
    '{OP_DATAGRAM, 11'd100,  MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd5,
      16'd5,     1'b1, DISP_BAD_FRAG},
    '{OP_DATAGRAM, 11'd2047, MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd1,     1'b1, DISP_BAD_FRAG},
    '{OP_DATAGRAM, 11'd16,   MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'hFFFF,  1'b1, DISP_BAD_FRAG},
    '{OP_DATAGRAM, 11'd16,   MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd1,   16'd0,
      16'd8193,  1'b1, DISP_BAD_FRAG},
    '{OP_DATAGRAM, 11'd1216, MAGIC_RST,    8'd2,   PEER_A, 8'h01, 8'd3,   32'd10,  16'd0,
      16'd3,     1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd1216, MAGIC_RST,    8'd2,   PEER_A, 8'h01, 8'd3,   32'd10,  16'd0,
      16'd3,     1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd500,  MAGIC_RST,    8'd2,   PEER_A, 8'h01, 8'd3,   32'd5,   16'd1,
      16'd3,     1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd116,  MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd5,   16'd0,
      16'd2,     1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd116,  MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd5,   16'd3,
      16'd4,     1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd16,   MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd0,   32'd5,   16'd1,
      16'd2,     1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd1216, MAGIC_RST,    8'd2,   PEER_A, 8'hFD, 8'h80,  32'd20,  16'd8191,
      16'd8192,  1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd1216, MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'hFF,  32'd21,  16'd0,
      16'd1,     1'b0, DISP_NONE},
    '{OP_DATAGRAM, 11'd17,   MAGIC_RST,    8'd2,   PEER_A, 8'h00, 8'd1,   32'd40,  16'd0,
      16'd2,     1'b0, DISP_NONE},
    '{OP_TICK,     11'd0,    32'h0,        8'd0,   48'h0,  8'h00, 8'd0,   32'd0,   16'd0,
      16'd0,     1'b0, DISP_NONE},
    '{OP_CLEAR,    11'd0,    32'h0,        8'd0,   48'h0,  8'h00, 8'd0,   32'd0,   16'd0,
      16'd0,     1'b1, DISP_NONE},
    '{OP_DATAGRAM, 11'd16,   MAGIC_RST,    8'd2,   PEER_B, 8'h03, 8'd0,   32'd7,   16'd0,
      16'd1,     1'b1, DISP_ACK_SEEN}
  };

  function automatic logic [47:0] rand48();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[47:0];
  endfunction

  function automatic void empty_assembly();
    asm_active = 1'b0;
    asm_id     = '0;
    asm_type   = '0;
    asm_count  = '0;
    rcvd_count = '0;
    byte_total = '0;
    asm_age    = '0;
    seen_map   = '0;
  endfunction

  function automatic void reset_session();
    peer_known = preset_en;
    peer_addr  = preset_addr;
    empty_assembly();
    acked_id   = '0;
  endfunction

  function automatic outcome_t reassemble_step(input logic [1:0] op, input in_word_t w);
    outcome_t    o;
    int unsigned plen;
    logic [24:0] sum;
    o = '0;
    o.disp = DISP_NONE;
    plen = int'(w.datagram_bytes) - int'(HEADER_BYTES);
    case (op)
      OP_TICK: begin
        if (asm_active) begin
          if (asm_age != 16'hFFFF) asm_age = asm_age + 16'd1;
          if (asm_age > tmo_ticks) begin
            empty_assembly();
            o.disp = DISP_STALE;
          end
        end
      end
      OP_CLEAR: reset_session();
      OP_DATAGRAM: begin
        if (int'(w.datagram_bytes) < int'(HEADER_BYTES)) begin
          o.disp = DISP_SHORT;
        end else if (w.header_magic != want_magic || w.header_version != want_version) begin
          o.disp = DISP_BAD_HDR;
        end else if (peer_known && w.source_address != peer_addr) begin
          o.disp = DISP_FOREIGN;
        end else begin
          peer_known = 1'b1;
          peer_addr  = w.source_address;
          if (w.packet_flags[1]) begin
            acked_id = w.message_id;
            o.disp = DISP_ACK_SEEN;
          end else if (w.fragment_count == 16'd0 || w.fragment_index >= w.fragment_count ||
                       plen > MAX_PAYLOAD || int'(w.fragment_count) > int'(MAX_FRAGMENTS)) begin
            o.disp = DISP_BAD_FRAG;
          end else begin
            if (w.packet_flags[0]) begin
              o.word.send_ack   = 1'b1;
              o.word.ack_for_id = w.message_id;
            end
            if (asm_active && w.message_id != asm_id && w.message_type != video_code &&
                w.message_id <= asm_id && rcvd_count != 14'd0) begin
              o.disp = DISP_OLDER;
            end else begin
              if (asm_active && w.message_id != asm_id) begin
                empty_assembly();
                o.word.assembly_restarted = 1'b1;
              end
              if (!asm_active) begin
                empty_assembly();
                asm_active = 1'b1;
                asm_id     = w.message_id;
                asm_type   = w.message_type;
                asm_count  = w.fragment_count[13:0];
              end
              if (int'(w.fragment_index) >= int'(asm_count)) begin
                o.disp = DISP_BAD_FRAG;
              end else begin
                if (!seen_map[w.fragment_index[12:0]]) begin
                  seen_map[w.fragment_index[12:0]] = 1'b1;
                  rcvd_count = rcvd_count + 14'd1;
                  sum = {1'b0, byte_total} + 25'(plen);
                  byte_total = sum[24] ? 24'hFFFFFF : sum[23:0];
                  o.disp = DISP_STORED;
                  o.word.store_fragment  = 1'b1;
                  o.word.fragment_slot   = w.fragment_index[12:0];
                  o.word.fragment_length = 11'(plen);
                end else begin
                  o.disp = DISP_DUPLICATE;
                end
                if (rcvd_count == asm_count) begin
                  o.word.done_type  = asm_type;
                  o.word.done_bytes = byte_total;
                  if (byte_total <= max_bytes) o.word.message_done = 1'b1;
                  else o.word.oversize_dropped = 1'b1;
                  empty_assembly();
                end
              end
            end
          end
        end
      end
      default: ;
    endcase
    o.word.last_acked_id = acked_id;
    return o;
  endfunction

  function automatic in_word_t datagram(input logic [31:0] id, input logic [7:0] ty,
                                        input logic [15:0] idx, input logic [15:0] cnt,
                                        input logic [7:0] flags);
    in_word_t w;
    w = '0;
    w.datagram_bytes = 11'($urandom_range(1216, 16));
    w.header_magic   = want_magic;
    w.header_version = want_version;
    w.source_address = peer_known ? peer_addr : rand48();
    w.packet_flags   = flags;
    w.message_type   = ty;
    w.message_id     = id;
    w.fragment_index = idx;
    w.fragment_count = cnt;
    return w;
  endfunction

  task automatic send_word(input logic [1:0] op, input in_word_t w, input bit typed,
                           input disp_e typed_disp);
    outcome_t o;
    o = reassemble_step(op, w);
    if (typed) o.disp = typed_disp;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= w;
    s_axis_tuser  <= op;
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results = {pending_results, o};
    @(negedge clk_i);
  endtask

  task automatic wait_results_in();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk_i); while (pending_results.size() != 0);
  endtask

  task automatic program_regs(input logic [31:0] magic, input logic [7:0] ver,
                              input logic [7:0] video, input logic [15:0] tmo,
                              input logic [23:0] maxb, input logic pen,
                              input logic [47:0] paddr);
    logic [47:0] vals [7];
    vals[CFG_MAGIC]       = 48'(magic);
    vals[CFG_VERSION]     = 48'(ver);
    vals[CFG_VIDEO_TYPE]  = 48'(video);
    vals[CFG_TIMEOUT]     = 48'(tmo);
    vals[CFG_MAX_BYTES]   = 48'(maxb);
    vals[CFG_PRESET_EN]   = 48'(pen);
    vals[CFG_PRESET_ADDR] = paddr;
    for (int i = 0; i < 7; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
    want_magic   = magic;
    want_version = ver;
    video_code   = video;
    tmo_ticks    = tmo;
    max_bytes    = maxb;
    preset_en    = pen;
    preset_addr  = paddr;
  endtask

  // mostly well-formed fragment streams, with ticks, stale ids, acks and junk mixed in
  task automatic random_words(input int n);
    int          k;
    in_word_t    w;
    in_word_t    nz;
    logic [1:0]  op;
    logic [7:0]  fl;
    logic [15:0] idx;
    logic [15:0] cnt;
    logic [7:0]  ty;
    repeat (n) begin
      nz.pad            = '0;
      nz.datagram_bytes = 11'($urandom);
      nz.header_magic   = $urandom;
      nz.header_version = 8'($urandom);
      nz.source_address = rand48();
      nz.packet_flags   = 8'($urandom);
      nz.message_type   = 8'($urandom);
      nz.message_id     = $urandom;
      nz.fragment_index = 16'($urandom);
      nz.fragment_count = 16'($urandom);
      op = OP_DATAGRAM;
      fl = 8'($urandom);
      fl[1] = 1'b0;
      k = $urandom_range(99);
      w = nz;
      if (k < 72) begin
        if (next_frag >= cur_cnt || $urandom_range(19) == 0) begin
          cur_id    = ($urandom_range(7) == 0) ? $urandom : cur_id + 32'($urandom_range(3, 1));
          cur_cnt   = ($urandom_range(49) == 0) ? 16'($urandom_range(MAX_FRAGMENTS, 7))
                                                : 16'($urandom_range(6, 1));
          cur_type  = 8'($urandom);
          next_frag = '0;
        end
        if ($urandom_range(3) == 0) begin
          idx = 16'($urandom_range(int'(cur_cnt) - 1));
        end else begin
          idx = next_frag;
          next_frag = next_frag + 16'd1;
        end
        cnt = ($urandom_range(19) == 0) ? 16'($urandom) : cur_cnt;
        ty  = ($urandom_range(9) == 0) ? video_code : cur_type;
        w = datagram(cur_id, ty, idx, cnt, fl);
      end else if (k < 80) begin
        op = OP_TICK;
      end else if (k < 84) begin
        w = datagram(cur_id - 32'($urandom_range(4, 1)), cur_type,
                     16'($urandom_range(int'(cur_cnt) - 1)), cur_cnt, fl);
      end else if (k < 87) begin
        fl[1] = 1'b1;
        w = datagram($urandom, cur_type, 16'd0, 16'd1, fl);
      end else if (k < 94) begin
        w = datagram(cur_id, cur_type, 16'd0, cur_cnt, fl);
        case ($urandom_range(4))
          0: w.datagram_bytes = 11'($urandom_range(15));
          1: w.header_magic = nz.header_magic;
          2: w.header_version = nz.header_version;
          3: w.source_address = nz.source_address;
          default: begin
            w.datagram_bytes = nz.datagram_bytes;
            w.fragment_index = nz.fragment_index;
            w.fragment_count = nz.fragment_count;
          end
        endcase
      end else if (k < 97) begin
        op = 2'($urandom);
      end else if (k < 98) begin
        op = OP_CLEAR;
      end else begin
        op = OP_UNUSED;
      end
      send_word(op, w, 1'b0, DISP_NONE);
    end
  endtask

  function automatic void cmp(input string name, input logic [47:0] want,
                              input logic [47:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  outcome_t  want_res;
  out_word_t got_word;

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        $error("result word with nothing expected, disposition %0d", m_axis_tuser);
        mismatches++;
      end else begin
        want_res = pending_results.pop_front();
        got_word = out_word_t'(m_axis_tdata);
        cmp("disposition", 48'(want_res.disp), 48'(m_axis_tuser));
        cmp("send_ack", 48'(want_res.word.send_ack), 48'(got_word.send_ack));
        cmp("ack_for_id", 48'(want_res.word.ack_for_id), 48'(got_word.ack_for_id));
        cmp("assembly_restarted", 48'(want_res.word.assembly_restarted),
            48'(got_word.assembly_restarted));
        cmp("store_fragment", 48'(want_res.word.store_fragment),
            48'(got_word.store_fragment));
        cmp("fragment_slot", 48'(want_res.word.fragment_slot), 48'(got_word.fragment_slot));
        cmp("fragment_length", 48'(want_res.word.fragment_length),
            48'(got_word.fragment_length));
        cmp("message_done", 48'(want_res.word.message_done), 48'(got_word.message_done));
        cmp("done_type", 48'(want_res.word.done_type), 48'(got_word.done_type));
        cmp("done_bytes", 48'(want_res.word.done_bytes), 48'(got_word.done_bytes));
        cmp("oversize_dropped", 48'(want_res.word.oversize_dropped),
            48'(got_word.oversize_dropped));
        cmp("last_acked_id", 48'(want_res.word.last_acked_id),
            48'(got_word.last_acked_id));
      end
    end
  end

  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      rx_hold_left = rx_hold_left - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    tx_idle_pct = 16;
    rx_idle_pct = 72;
    program_regs(MAGIC_RST, VERSION_RST, VIDEO_RST, TIMEOUT_RST, MAX_BYTES_RST,
                 PRESET_EN_RST, PRESET_ADDR_RST);
    reset_session();
    foreach (script[i]) begin
      send_word(script[i].op,
                '{pad: '0, fragment_count: script[i].fcnt, fragment_index: script[i].fidx,
                  message_id: script[i].mid, message_type: script[i].mtype,
                  packet_flags: script[i].flags, source_address: script[i].src,
                  header_version: script[i].ver, header_magic: script[i].magic,
                  datagram_bytes: script[i].dlen},
                script[i].typed, script[i].disp);
    end
    random_words(260);
    wait_results_in();

    // timeout and size of one, fixed peer
    tx_idle_pct = 72;
    rx_idle_pct = 16;
    program_regs(32'h0, 8'h0, 8'hFF, 16'd1, 24'd1, 1'b1, 48'hFFFF_FFFF_FFFF);
    send_word(OP_CLEAR, '0, 1'b0, DISP_NONE);
    random_words(280);
    wait_results_in();

    // maximum magic, version and timeout, learned peer
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    program_regs(32'hFFFF_FFFF, 8'hFF, 8'h5A, 16'hFFFF, 24'd9830400, 1'b0, rand48());
    send_word(OP_CLEAR, '0, 1'b0, DISP_NONE);
    random_words(280);
    wait_results_in();

    // back-pressure: long receiver hold-off, then the sender waits for a full drain
    program_regs($urandom, 8'($urandom), 8'($urandom), 16'($urandom_range(20, 2)),
                 24'($urandom_range(50000, 1000)), 1'b1, rand48());
    send_word(OP_CLEAR, '0, 1'b0, DISP_NONE);
    rx_hold_left = 400;
    random_words(150);
    wait_results_in();
    random_words(150);
    wait_results_in();

    repeat (12) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
